@@ src/lmacc_pkg.sv @@
// Shared constants and types for the Legendre moment accumulator.
package lmacc_pkg;

    localparam int BIN_COUNT     = 256;
    localparam int MAX_ORDER     = 7;
    localparam int MAX_AXES      = 3;
    localparam int SLOTS_PER_BIN = MAX_AXES * (MAX_ORDER + 1);
    localparam int MEM_DEPTH     = BIN_COUNT * SLOTS_PER_BIN;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int BIN_W         = 8;
    localparam int SLOT_W        = 5;
    localparam int ORD_W         = 3;
    localparam int SEL_W         = 2;

    // Recurrence numerator and divider sizing
    localparam int NUM_W     = 37;
    localparam int MAG_W     = NUM_W - 1;
    localparam int DIG_W     = 6;
    localparam int DIG_COUNT = MAG_W / DIG_W;
    localparam int DCNT_W    = $clog2(DIG_COUNT);

    // Input and output bus widths
    localparam int S_TDATA_W = 328;
    localparam int M_TDATA_W = 72;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_AXIS_COUNT   = 3'd0,
        CFG_FIRST_AXIS   = 3'd1,
        CFG_SECOND_AXIS  = 3'd2,
        CFG_THIRD_AXIS   = 3'd3,
        CFG_FIRST_ORDER  = 3'd4,
        CFG_SECOND_ORDER = 3'd5,
        CFG_THIRD_ORDER  = 3'd6
    } cfg_index_t;

    localparam logic [SEL_W-1:0] SEL_X = 2'd0;
    localparam logic [SEL_W-1:0] SEL_Y = 2'd1;
    localparam logic [SEL_W-1:0] SEL_Z = 2'd2;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // Divider request from the sequencer
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [ORD_W-1:0]        den;
    } div_req_t;

    // Divider answer to the sequencer
    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ src/lmacc_div.sv @@
// Digit-serial signed divider by a small order number, truncating toward zero.
module lmacc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmacc_pkg::div_req_t req,
    output lmacc_pkg::div_rsp_t rsp
);
    import lmacc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DCNT_W-1:0]    cnt_reg;
    logic [MAG_W-1:0]     dvd_reg;
    logic [MAG_W-1:0]     quo_reg;
    logic [ORD_W-1:0]     rem_reg;
    logic [ORD_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [ORD_W-1:0]     rem_next;
    logic [DIG_W-1:0]     dig_next;
    logic [NUM_W-1:0]     mag_w;

    assign mag_w = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);

    // Work off one digit of the dividend per cycle
    always_comb begin
        logic [ORD_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < DIG_W; i++) begin
            r = {r[ORD_W-1:0], dvd_reg[MAG_W-1-i]};
            if (r >= {1'b0, den_reg}) begin
                r = r - {1'b0, den_reg};
                dig_next[DIG_W-1-i] = 1'b1;
            end else begin
                dig_next[DIG_W-1-i] = 1'b0;
            end
        end
        rem_next = r[ORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIG_COUNT - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the operands and shift the quotient in
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= mag_w[MAG_W-1:0];
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= req.den;
            neg_reg <= req.num[NUM_W-1];
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
            quo_reg <= {quo_reg[MAG_W-DIG_W-1:0], dig_next};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> den_reg != '0)
        else $error("divider started with zero divisor");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");

endmodule

@@ src/legendre_moment_accumulator_core.sv @@
// Top level: Legendre moment accumulator with one memory holding every bin slot.
//
//  channel  | direction | contents
//  s_       | in        | score or read item (tuser = op)
//  m_       | out       | coefficient of a read run (tlast = last)
//  cfg_     | in        | register write, index and data
//
// After reset the accumulator memory, 6144 words, is swept to zero with s_tready low.
// Score item: each axis maps its coordinate, then each order scales the score and
// updates its slot; higher orders first run the recurrence on the 6-digit divider.
// Read item: one coefficient at a time via the single read port, held by sink stalls.
// One item is in work at a time; configuration writes are always taken.
module legendre_moment_accumulator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bin_index, score, pos_x, pos_y, pos_z, lower_x, lower_y, lower_z,
    // inv_width_x, inv_width_y, inv_width_z, zero pad
    input  logic [lmacc_pkg::S_TDATA_W-1:0]     s_tdata,
    // op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // coeff_slot, coeff_value, zero pad
    output logic [lmacc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [2:0]                          cfg_data
);
    import lmacc_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_AX_SUB  = 14'b00000000000100,
        S_AX_MUL  = 14'b00000000001000,
        S_AX_X    = 14'b00000000010000,
        S_ORD_SC  = 14'b00000000100000,
        S_RMW_RD  = 14'b00000001000000,
        S_RMW_WR  = 14'b00000010000000,
        S_ORD_MUL = 14'b00000100000000,
        S_ORD_NUM = 14'b00001000000000,
        S_ORD_DIV = 14'b00010000000000,
        S_RD_ISS  = 14'b00100000000000,
        S_RD_WAIT = 14'b01000000000000,
        S_RD_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [1:0]       axis_count_reg;
    logic [SEL_W-1:0] sel_reg [MAX_AXES];
    logic [ORD_W-1:0] ord_cfg_reg [MAX_AXES];

    // Item registers
    logic                    op_reg;
    logic [BIN_W-1:0]        bin_reg;
    logic signed [31:0]      score_reg;
    logic signed [31:0]      pos_reg [3];
    logic signed [31:0]      low_reg [3];
    logic [30:0]             inv_reg [3];

    // Sequencer and datapath registers
    logic [ADDR_W-1:0]       clr_reg;
    logic [1:0]              axis_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       total_reg;
    logic [ORD_W-1:0]        n_reg;
    logic [ORD_W-1:0]        ord_reg;
    logic signed [32:0]      d_reg;
    logic [30:0]             inv_sel_reg;
    logic signed [63:0]      xp_reg;
    logic signed [31:0]      x_reg;
    logic signed [31:0]      p0_reg;
    logic signed [31:0]      p1_reg;
    logic signed [31:0]      p2_reg;
    logic signed [63:0]      prod_reg;
    logic signed [63:0]      bprod_reg;
    logic signed [63:0]      beta_reg;
    logic signed [63:0]      rdata_reg;
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [63:0]             out_value_reg;
    logic                    out_last_reg;

    // Memory
    logic [63:0]             mem [MEM_DEPTH];
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [63:0]             mem_wdata;
    logic [ADDR_W-1:0]       addr_w;

    // Combinational helpers
    logic [1:0]              naxes_w;
    logic [SLOT_W-1:0]       total_w;
    logic [SEL_W-1:0]        sel_w;
    logic signed [63:0]      xs_w;
    logic signed [31:0]      xc_w;
    logic signed [33:0]      t_w;
    logic [3:0]              c1_w;
    logic [ORD_W-1:0]        c2_w;
    logic signed [NUM_W-1:0] num_w;
    logic signed [31:0]      pclamp_w;
    logic signed [63:0]      sum_w;
    logic signed [63:0]      sat_w;
    logic                    accept_w;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign accept_w  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Effective axis count: zero acts as one
    assign naxes_w = (axis_count_reg == 2'd0) ? 2'd1 : axis_count_reg;

    // Run length of a read
    always_comb begin
        total_w = SLOT_W'({2'b0, ord_cfg_reg[0]}) + 1'b1;
        if (naxes_w >= 2'd2) total_w = total_w + SLOT_W'({2'b0, ord_cfg_reg[1]}) + 1'b1;
        if (naxes_w == 2'd3) total_w = total_w + SLOT_W'({2'b0, ord_cfg_reg[2]}) + 1'b1;
    end

    // Selector three acts as z
    assign sel_w = (sel_reg[axis_reg] == 2'd3) ? SEL_Z : sel_reg[axis_reg];

    assign addr_w = ADDR_W'(bin_reg) * ADDR_W'(SLOTS_PER_BIN) + ADDR_W'(slot_reg);

    // Map the product to [-1, 1] in Q2.30
    always_comb begin
        xs_w = (xp_reg >>> 1) - 64'sh4000_0000;
        if (xs_w < -64'sh4000_0000)     xc_w = -Q30_ONE;
        else if (xs_w > 64'sh4000_0000) xc_w = Q30_ONE;
        else                            xc_w = xs_w[31:0];
    end

    // Recurrence numerator
    assign t_w   = 34'((prod_reg + 64'sh2000_0000) >>> 30);
    assign c1_w  = {n_reg, 1'b0} - 4'd1;
    assign c2_w  = n_reg - 1'b1;
    assign num_w = NUM_W'(t_w) * $signed(NUM_W'(c1_w))
                 - NUM_W'(p0_reg) * $signed(NUM_W'(c2_w));

    assign div_req.start = (state_reg == S_ORD_NUM);
    assign div_req.num   = num_w;
    assign div_req.den   = n_reg;

    lmacc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Clamp the quotient to the Q2.30 word
    always_comb begin
        if (div_rsp.quot > NUM_W'(64'sh7FFF_FFFF))       pclamp_w = 32'sh7FFF_FFFF;
        else if (div_rsp.quot < -NUM_W'(64'sh8000_0000)) pclamp_w = -32'sh8000_0000;
        else                                             pclamp_w = div_rsp.quot[31:0];
    end

    // Saturating accumulate
    assign sum_w = rdata_reg + beta_reg;
    always_comb begin
        if (!rdata_reg[63] && !beta_reg[63] && sum_w[63])      sat_w = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (rdata_reg[63] && beta_reg[63] && !sum_w[63]) sat_w = -64'sh8000_0000_0000_0000;
        else                                                   sat_w = sum_w;
    end

    // Memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_w;
        mem_wdata = sat_w;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end else if (state_reg == S_RMW_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[addr_w];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (clr_reg == ADDR_W'(MEM_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:    if (accept_w) state_next = s_tuser ? S_RD_ISS : S_AX_SUB;
            S_AX_SUB:  state_next = S_AX_MUL;
            S_AX_MUL:  state_next = S_AX_X;
            S_AX_X:    state_next = S_ORD_SC;
            S_ORD_SC:  state_next = S_RMW_RD;
            S_RMW_RD:  state_next = S_RMW_WR;
            S_RMW_WR: begin
                if (n_reg != ord_reg)                   state_next = S_ORD_MUL;
                else if (axis_reg + 2'd1 == naxes_w)    state_next = S_IDLE;
                else                                    state_next = S_AX_SUB;
            end
            S_ORD_MUL: state_next = S_ORD_NUM;
            S_ORD_NUM: state_next = S_ORD_DIV;
            S_ORD_DIV: if (div_rsp.done) state_next = S_ORD_SC;
            S_RD_ISS:  state_next = S_RD_WAIT;
            S_RD_WAIT: state_next = S_RD_OUT;
            S_RD_OUT: begin
                if (m_tready) state_next = out_last_reg ? S_IDLE : S_RD_ISS;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            axis_count_reg <= 2'd1;
            sel_reg[0]     <= SEL_X;
            sel_reg[1]     <= SEL_Y;
            sel_reg[2]     <= SEL_Z;
            ord_cfg_reg[0] <= '0;
            ord_cfg_reg[1] <= '0;
            ord_cfg_reg[2] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_RD_WAIT) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_AXIS_COUNT:   axis_count_reg <= cfg_data[1:0];
                    CFG_FIRST_AXIS:   sel_reg[0]     <= cfg_data[1:0];
                    CFG_SECOND_AXIS:  sel_reg[1]     <= cfg_data[1:0];
                    CFG_THIRD_AXIS:   sel_reg[2]     <= cfg_data[1:0];
                    CFG_FIRST_ORDER:  ord_cfg_reg[0] <= cfg_data;
                    CFG_SECOND_ORDER: ord_cfg_reg[1] <= cfg_data;
                    CFG_THIRD_ORDER:  ord_cfg_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                op_reg     <= s_tuser;
                bin_reg    <= s_tdata[7:0];
                score_reg  <= s_tdata[39:8];
                pos_reg[0] <= s_tdata[71:40];
                pos_reg[1] <= s_tdata[103:72];
                pos_reg[2] <= s_tdata[135:104];
                low_reg[0] <= s_tdata[167:136];
                low_reg[1] <= s_tdata[199:168];
                low_reg[2] <= s_tdata[231:200];
                inv_reg[0] <= s_tdata[262:232];
                inv_reg[1] <= s_tdata[293:263];
                inv_reg[2] <= s_tdata[324:294];
                axis_reg   <= '0;
                slot_reg   <= '0;
                total_reg  <= total_w;
            end
            S_AX_SUB: begin
                d_reg       <= 33'(pos_reg[sel_w]) - 33'(low_reg[sel_w]);
                inv_sel_reg <= inv_reg[sel_w];
                ord_reg     <= ord_cfg_reg[axis_reg];
                n_reg       <= '0;
            end
            S_AX_MUL: xp_reg <= 64'(d_reg) * $signed(64'(inv_sel_reg));
            S_AX_X: begin
                x_reg  <= xc_w;
                p0_reg <= Q30_ONE;
                p1_reg <= Q30_ONE;
                p2_reg <= Q30_ONE;
            end
            S_ORD_SC:  bprod_reg <= 64'(score_reg) * 64'(p2_reg);
            S_RMW_RD:  beta_reg <= (bprod_reg + 64'sd8192) >>> 14;
            S_RMW_WR: begin
                slot_reg <= slot_reg + 1'b1;
                if (n_reg != ord_reg) begin
                    n_reg <= n_reg + 1'b1;
                end else begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            S_ORD_MUL: prod_reg <= 64'(x_reg) * 64'(p1_reg);
            S_ORD_DIV: begin
                if (div_rsp.done) begin
                    p2_reg <= pclamp_w;
                    p0_reg <= p1_reg;
                    p1_reg <= pclamp_w;
                end
            end
            S_RD_WAIT: begin
                out_slot_reg  <= slot_reg;
                out_value_reg <= rdata_reg;
                out_last_reg  <= (slot_reg + 1'b1 == total_reg);
            end
            S_RD_OUT:  if (m_tready) slot_reg <= slot_reg + 1'b1;
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result waits");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RMW_WR) |-> (slot_reg < SLOT_W'(SLOTS_PER_BIN)))
        else $error("slot beyond bin");
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_ORD_DIV))
        else $error("divider answer outside wait");
    a_read_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> op_reg)
        else $error("result from a score item");

endmodule

@@ test/lmacc_tb_pkg.sv @@
// Item type, operation codes and bus packing shared by the accumulator testbench.
package lmacc_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {
        OP_SCORE = 1'b0,
        OP_READ  = 1'b1
    } lm_op_t;

    typedef struct {
        lm_op_t             op;
        bit [7:0]           bin;
        bit signed [31:0]   score;
        bit signed [31:0]   pos[3];
        bit signed [31:0]   lower[3];
        bit [30:0]          inv[3];
    } lm_item_t;

    // Lay out the fields on the input bus, bin index in the lowest bits
    function automatic logic [lmacc_pkg::S_TDATA_W-1:0] pack_item(lm_item_t it);
        logic [lmacc_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[7:0]  = it.bin;
        d[39:8] = it.score;
        for (int a = 0; a < 3; a++) begin
            d[40 + 32*a +: 32]  = it.pos[a];
            d[136 + 32*a +: 32] = it.lower[a];
            d[232 + 31*a +: 31] = it.inv[a];
        end
        return d;
    endfunction

endpackage

@@ test/legendre_moment_accumulator_checker.sv @@
// Checker: tracks register writes, predicts coefficient runs and compares the result stream.
module legendre_moment_accumulator_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [lmacc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [lmacc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tlast,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [2:0]                         cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 score_seen,
    output int                                 read_seen,
    output int                                 coeff_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import lmacc_pkg::*;
    import lmacc_tb_pkg::*;

    localparam longint Q30 = 64'sd1 << 30;

    typedef struct {
        bit [4:0]          slot;
        bit signed [63:0]  value;
        bit                last;
    } coeff_t;

    longint  moments[MEM_DEPTH];
    coeff_t  coeff_due[$];
    bit [1:0] axis_count_r;
    bit [1:0] axis_sel_r[3];
    bit [2:0] order_r[3];

    function automatic int axes_in_use();
        return (axis_count_r == 0) ? 1 : int'(axis_count_r);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) s = 64'h7FFF_FFFF_FFFF_FFFF;
        if (a[63] && b[63] && !s[63])  s = 64'h8000_0000_0000_0000;
        return s;
    endfunction

    // Spread one score over the Legendre slots of its bin
    function automatic void tally_score(logic [S_TDATA_W-1:0] d);
        int     base, slot, sel;
        longint sc, pos, low, inv, x, p0, p1, p2, t, num, beta;
        base = int'(d[7:0]) * SLOTS_PER_BIN;
        sc   = longint'($signed(d[39:8]));
        slot = 0;
        for (int a = 0; a < axes_in_use(); a++) begin
            sel = (axis_sel_r[a] > 2) ? 2 : int'(axis_sel_r[a]);
            pos = longint'($signed(d[40 + 32*sel +: 32]));
            low = longint'($signed(d[136 + 32*sel +: 32]));
            inv = longint'({33'd0, d[232 + 31*sel +: 31]});
            x = (((pos - low) * inv) >>> 1) - Q30;
            if (x < -Q30) x = -Q30;
            if (x > Q30) x = Q30;
            p0 = Q30;
            p1 = Q30;
            p2 = Q30;
            for (int n = 0; n <= int'(order_r[a]); n++) begin
                if (n > 0) begin
                    t   = (x * p1 + (64'sd1 <<< 29)) >>> 30;
                    num = longint'(2*n - 1) * t - longint'(n - 1) * p0;
                    p2  = num / longint'(n);
                    if (p2 > 64'sd2147483647) p2 = 64'sd2147483647;
                    if (p2 < -64'sd2147483648) p2 = -64'sd2147483648;
                    p0 = p1;
                    p1 = p2;
                end
                beta = (sc * p2 + 64'sd8192) >>> 14;
                moments[base + slot] = sat_sum(moments[base + slot], beta);
                slot++;
            end
        end
    endfunction

    // Queue the coefficient run that a read returns
    function automatic void queue_read(int bin);
        int     total;
        coeff_t c;
        total = 0;
        for (int a = 0; a < axes_in_use(); a++) total += int'(order_r[a]) + 1;
        for (int s = 0; s < total; s++) begin
            c.slot  = s[4:0];
            c.value = moments[bin * SLOTS_PER_BIN + s];
            c.last  = (s + 1 == total);
            coeff_due = {coeff_due, c};
        end
    endfunction

    always @(posedge aclk) begin
        coeff_t c;
        if (!aresetn) begin
            for (int i = 0; i < MEM_DEPTH; i++) moments[i] = 0;
            axis_count_r  = 2'd1;
            axis_sel_r[0] = SEL_X;
            axis_sel_r[1] = SEL_Y;
            axis_sel_r[2] = SEL_Z;
            for (int a = 0; a < 3; a++) order_r[a] = 3'd0;
            coeff_due.delete();
            fail_count = 0;
            score_seen = 0;
            read_seen  = 0;
            coeff_seen = 0;
        end else begin
            // Compare each returned coefficient with the oldest one due
            if (m_tvalid && m_tready) begin
                coeff_seen++;
                if (coeff_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected coefficient slot %0d value %0d",
                                 m_tdata[4:0], $signed(m_tdata[68:5]));
                end else begin
                    c = coeff_due.pop_front();
                    if (m_tdata[4:0] !== c.slot || $signed(m_tdata[68:5]) !== c.value
                        || m_tlast !== c.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display(
                                "ERROR: coeff exp slot %0d val %0d last %0b, got %0d %0d %0b",
                                c.slot, c.value, c.last, m_tdata[4:0],
                                $signed(m_tdata[68:5]), m_tlast);
                    end
                end
            end
            // Predict each accepted input transaction
            if (s_tvalid && s_tready) begin
                if (lm_op_t'(s_tuser) == OP_READ) begin
                    read_seen++;
                    queue_read(int'(s_tdata[7:0]));
                end else begin
                    score_seen++;
                    tally_score(s_tdata);
                end
            end
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_AXIS_COUNT:   axis_count_r  = cfg_data[1:0];
                    CFG_FIRST_AXIS:   axis_sel_r[0] = cfg_data[1:0];
                    CFG_SECOND_AXIS:  axis_sel_r[1] = cfg_data[1:0];
                    CFG_THIRD_AXIS:   axis_sel_r[2] = cfg_data[1:0];
                    CFG_FIRST_ORDER:  order_r[0]    = cfg_data;
                    CFG_SECOND_ORDER: order_r[1]    = cfg_data;
                    CFG_THIRD_ORDER:  order_r[2]    = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = coeff_due.size();
    end

endmodule

@@ test/legendre_moment_accumulator_core_tb.sv @@
// Testbench top: drives score, read and register transactions and reports the verdict.
module legendre_moment_accumulator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lmacc_pkg::*;
    import lmacc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 400;
    localparam int PHASES      = 7;
    localparam int RAND_ITEMS  = 58;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [2:0]            cfg_data = '0;

    int  fail_count, pending, score_seen, read_seen, coeff_seen;
    int  cycles = 0;
    bit  quiet = 1'b0;

    legendre_moment_accumulator_core i_dut (.*);

    legendre_moment_accumulator_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result sink: stall in bursts until the quiet tail
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (quiet) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                n = $urandom_range(1, 30);
                m_tready <= 1'b1;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Hold valid after the write; the caller drops it once the batch is done
    task automatic write_reg(cfg_index_t idx, bit [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic send(lm_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.op;
        do @(posedge aclk); while (!s_tready);
        // Idle the source now and then
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Build a transaction; most scores land inside a sane bin, some are raw noise
    function automatic lm_item_t make_item(bit wild);
        lm_item_t it;
        int       span;
        it.op    = ($urandom_range(0, 3) == 0) ? OP_READ : OP_SCORE;
        it.bin   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        it.score = wild ? $urandom : 32'($urandom_range(0, 1 << 20)) - 32'sd1 <<< 0;
        if (!wild && $urandom_range(0, 1)) it.score = -it.score;
        for (int a = 0; a < 3; a++) begin
            if (wild) begin
                it.pos[a]   = $urandom;
                it.lower[a] = $urandom;
                it.inv[a]   = 31'($urandom);
            end else begin
                it.inv[a]   = 31'($urandom_range(1 << 10, 1 << 22));
                span        = int'(32'hFFFF_FFFF / it.inv[a]);
                it.lower[a] = 32'($urandom_range(0, 1 << 24)) - 32'sd8388608;
                it.pos[a]   = it.lower[a] + 32'($urandom_range(0, span + span / 8));
            end
        end
        return it;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic read_bin(bit [7:0] bin);
        lm_item_t it;
        it = make_item(1'b0);
        it.op  = OP_READ;
        it.bin = bin;
        send(it);
    endtask

    initial begin
        bit [2:0] cfg_set[PHASES][7] = '{
            '{3'd1, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0},
            '{3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd7, 3'd7},
            '{3'd0, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0},
            '{3'd2, 3'd2, 3'd0, 3'd1, 3'd3, 3'd5, 3'd1},
            '{3'd3, 3'd3, 3'd2, 3'd1, 3'd2, 3'd7, 3'd4},
            '{3'd1, 3'd1, 3'd0, 3'd0, 3'd6, 3'd0, 3'd0},
            '{3'd3, 3'd1, 3'd1, 3'd1, 3'd7, 3'd0, 3'd7}};
        lm_item_t it;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Reprogram while idle; phase zero runs on reset values
            if (ph > 0) begin
                for (int r = 0; r < 7; r++) write_reg(cfg_index_t'(r), cfg_set[ph][r]);
                cfg_valid <= 1'b0;
            end
            if (ph == PHASES - 1) quiet = 1'b1;

            // Directed corners under the widest configuration
            if (ph == 1) begin
                it = make_item(1'b0);
                it.op = OP_SCORE;
                for (int k = 0; k < 10; k++) begin
                    it.bin = (k < 5) ? 8'd255 : 8'd0;
                    case (k)
                        0: begin it.score = 32'h7FFF_FFFF; it.pos = '{0, 0, 0};
                           it.lower = '{0, 0, 0}; it.inv = '{0, 0, 0}; end
                        1: begin it.score = 32'h8000_0000; it.pos = '{32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF}; it.lower = '{32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000}; it.inv = '{31'h7FFF_FFFF,
                           31'h7FFF_FFFF, 31'h7FFF_FFFF}; end
                        2: begin it.pos = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                           it.lower = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; end
                        3: begin it.score = 32'h0001_0000; it.pos = '{32'h10000, 0, 32'h8000};
                           it.lower = '{0, 0, 0}; it.inv = '{31'h10000, 31'h10000,
                           31'h10000}; end
                        4: begin it.score = 32'hFFFF_FFFF; it.pos = '{32'h4000, 32'h2000,
                           32'hC000}; end
                        default: it = make_item(k[0]);
                    endcase
                    it.op = OP_SCORE;
                    send(it);
                end
                read_bin(8'd255);
                read_bin(8'd0);
                read_bin(8'd128);
            end

            // Random transactions
            for (int k = 0; k < RAND_ITEMS; k++) send(make_item($urandom_range(0, 5) == 0));
            for (int b = 0; b < 6; b++) read_bin(b[7:0]);
            drain();
        end

        $display("Covered %0d score and %0d read transactions, %0d coefficients returned,",
                 score_seen, read_seen, coeff_seen);
        $display("over %0d register settings including axis and order extremes.", PHASES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
